### rtl/bse_pkg.sv
// Shared types and constants for the byte stack engine.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package bse_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;

   localparam int OP_W    = 3;
   localparam int BYTE_W  = 8;
   localparam int STS_W   = 2;
   localparam int DEPTH_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_DUP  = 3'd2,
      OP_ROLL = 3'd3,
      OP_ADD  = 3'd4,
      OP_MUL  = 3'd5,
      OP_DUMP = 3'd6
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_UNDER = 2'd1,
      STS_OVER  = 2'd2,
      STS_ROLL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROLL,
      ST_REPLY,
      ST_DUMP
   } state_type;

   // What every cell of the stack does in a cycle
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_DOWN,     // every cell takes its upper neighbor, top takes the new byte
      CMD_UP,       // every cell takes its lower neighbor
      CMD_TOP_UP,   // top takes the new byte, the rest take their lower neighbor
      CMD_SWAP      // the cell at the swap position trades with the one above it
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         shadow_load;
      logic         shadow_shift;
   } cell_ctl_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic               has_value;
      logic [BYTE_W-1:0]  value;
      logic               last;
      logic [STS_W-1:0]   status;
      logic [DEPTH_W-1:0] depth;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/bse_req_if.sv
// Request channel of the byte stack engine: valid, ready and one operation item.
// Depends on bse_pkg for the payload type.
`default_nettype none

interface bse_req_if import bse_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/bse_rsp_if.sv
// Response channel of the byte stack engine: valid, ready and one result item.
// Depends on bse_pkg for the payload type.
`default_nettype none

interface bse_rsp_if import bse_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/bse_cell.sv
// One stack slot: a data byte and a shadow byte used to stream the stack out.
// Depends on bse_pkg; instantiated in a row by byte_stack_engine_with_roll.
`default_nettype none

module bse_cell import bse_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 5
) (
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [IDX_W-1:0]  swap_pos,
   input  wire logic [BYTE_W-1:0] above_data,
   input  wire logic [BYTE_W-1:0] below_data,
   input  wire logic [BYTE_W-1:0] shadow_below,
   output logic [BYTE_W-1:0]      data_out,
   output logic [BYTE_W-1:0]      shadow_out
);

   localparam logic              IS_TOP    = (CELL_INDEX == 0);
   localparam logic [IDX_W-1:0]  MY_POS    = IDX_W'(CELL_INDEX);
   // Zero at the bottom of a power-of-two row; a swap position is never zero
   localparam logic [IDX_W-1:0]  ABOVE_POS = IDX_W'(CELL_INDEX + 1);

   logic [BYTE_W-1:0] data_ff, data_in;
   logic [BYTE_W-1:0] shadow_ff, shadow_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.cmd)
         CMD_HOLD:   data_in = data_ff;
         CMD_DOWN:   data_in = above_data;
         CMD_UP:     data_in = below_data;
         CMD_TOP_UP: data_in = IS_TOP ? above_data : below_data;
         CMD_SWAP: begin
            priority if (swap_pos == MY_POS) data_in = above_data;
            else if (swap_pos == ABOVE_POS) data_in = below_data;
            else data_in = data_ff;
         end
         default:    data_in = data_ff;
      endcase
   end

   always_comb begin
      priority if (ctl.shadow_load) shadow_in = data_ff;
      else if (ctl.shadow_shift) shadow_in = shadow_below;
      else shadow_in = shadow_ff;
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      shadow_ff <= shadow_in;
   end

   assign data_out   = data_ff;
   assign shadow_out = shadow_ff;

endmodule

`default_nettype wire

### rtl/byte_stack_engine_with_roll.sv
// Byte stack engine with roll. The stack is a row of STACK_DEPTH cells with the top
// in cell 0; push, pop, dup, add and mul shift the whole row by one place in their
// accept cycle, so such items are accepted back to back while the result register
// drains. Roll with a count n above zero pops the count, then makes n neighbor swaps
// that lift the chosen element to the top, then loads the result, which waits while
// the sink stalls; a count of zero loads its result on accept. Dump copies the
// row into the shadow chain in its accept cycle and then streams one element per
// cycle from the top whenever the sink is free, pausing while the sink stalls.
// Faults leave the stack unchanged and report in status. No clearing pass is needed.
// Depends on bse_pkg, bse_req_if, bse_rsp_if and bse_cell.
`default_nettype none

module byte_stack_engine_with_roll import bse_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   bse_req_if.sink   req_ch,
   bse_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
   localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);

   state_type         state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [SP_W-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   cell_ctl_type      ctl;
   logic [BYTE_W-1:0] top_in;
   logic [BYTE_W-1:0] cell_data   [STACK_DEPTH];
   logic [BYTE_W-1:0] cell_shadow [STACK_DEPTH];

   logic              out_free;
   logic              accept;
   logic              go_roll;
   logic              go_dump;
   logic              rsp_load;
   status_type        status;
   logic [SP_W-1:0]   sp_less;
   logic [BYTE_W-1:0] roll_n;
   logic [BYTE_W-1:0] sum_byte;
   logic [2*BYTE_W-1:0] product;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_ch.valid && req_ch.ready;

   assign sp_less  = sp_ff - SP_ONE;
   assign roll_n   = cell_data[0];
   assign sum_byte = cell_data[1] + cell_data[0];
   assign product  = cell_data[1] * cell_data[0];

   // Decode the item and drive the row
   always_comb begin
      ctl      = '{cmd: CMD_HOLD, shadow_load: 1'b0, shadow_shift: 1'b0};
      top_in   = req_ch.data.push_value;
      sp_in    = sp_ff;
      cnt_in   = cnt_ff;
      status   = STS_OK;
      go_roll  = 1'b0;
      go_dump  = 1'b0;
      rsp_load = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.data.operation)
                  OP_PUSH: begin
                     if (sp_ff == SP_FULL) status = STS_OVER;
                     else begin
                        ctl.cmd = CMD_DOWN;
                        sp_in   = sp_ff + SP_ONE;
                     end
                  end
                  OP_POP: begin
                     if (sp_ff == '0) status = STS_UNDER;
                     else begin
                        ctl.cmd = CMD_UP;
                        sp_in   = sp_less;
                     end
                  end
                  OP_DUP: begin
                     top_in = cell_data[0];
                     if (sp_ff == '0) status = STS_UNDER;
                     else if (sp_ff == SP_FULL) status = STS_OVER;
                     else begin
                        ctl.cmd = CMD_DOWN;
                        sp_in   = sp_ff + SP_ONE;
                     end
                  end
                  OP_ROLL: begin
                     if (sp_ff == '0) status = STS_UNDER;
                     else if (roll_n >= BYTE_W'(sp_less)) status = STS_ROLL;
                     else begin
                        // pop the count, then swap the element up n times
                        ctl.cmd = CMD_UP;
                        sp_in   = sp_less;
                        cnt_in  = SP_W'(roll_n);
                        go_roll = (roll_n != '0);
                     end
                  end
                  OP_ADD, OP_MUL: begin
                     top_in = (req_ch.data.operation == OP_ADD) ? sum_byte
                                                                : product[BYTE_W-1:0];
                     if (sp_ff < SP_TWO) status = STS_UNDER;
                     else begin
                        ctl.cmd = CMD_TOP_UP;
                        sp_in   = sp_less;
                     end
                  end
                  OP_DUMP: begin
                     if (sp_ff != '0) begin
                        ctl.shadow_load = 1'b1;
                        cnt_in  = sp_ff;
                        go_dump = 1'b1;
                     end
                  end
                  default: status = STS_OK;
               endcase

               if (!go_roll && !go_dump) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{has_value: 1'b0, value: '0, last: 1'b1,
                                  status: status, depth: DEPTH_W'(sp_in)};
               end
            end
         end
         ST_ROLL: begin
            ctl.cmd = CMD_SWAP;
            cnt_in  = cnt_ff - SP_ONE;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{has_value: 1'b0, value: '0, last: 1'b1,
                               status: STS_OK, depth: DEPTH_W'(sp_ff)};
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               ctl.shadow_shift = 1'b1;
               cnt_in      = cnt_ff - SP_ONE;
               rsp_load    = 1'b1;
               rsp_data_in = '{has_value: 1'b1, value: cell_shadow[0],
                               last: (cnt_ff == SP_ONE), status: STS_OK,
                               depth: DEPTH_W'(sp_ff)};
            end
         end
         default: ctl.cmd = CMD_HOLD;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            priority if (go_roll) state_in = ST_ROLL;
            else if (go_dump) state_in = ST_DUMP;
            else state_in = ST_IDLE;
         end
         ST_ROLL:  if (cnt_ff == SP_ONE) state_in = ST_REPLY;
         ST_REPLY: if (out_free) state_in = ST_IDLE;
         ST_DUMP:  if (out_free && cnt_ff == SP_ONE) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [BYTE_W-1:0] above;
      logic [BYTE_W-1:0] below;
      logic [BYTE_W-1:0] shadow_below;

      if (i == 0) begin : g_top
         assign above = top_in;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below        = '0;
         assign shadow_below = '0;
      end else begin : g_inner
         assign below        = cell_data[i+1];
         assign shadow_below = cell_shadow[i+1];
      end

      bse_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .swap_pos     (cnt_ff[IDX_W-1:0]),
         .above_data   (above),
         .below_data   (below),
         .shadow_below (shadow_below),
         .data_out     (cell_data[i]),
         .shadow_out   (cell_shadow[i])
      );
   end

endmodule

`default_nettype wire
